/* rtl/core/tlptm_pkg.sv */
// Package for the two-level page table manager core.
// Holds the beat types, operation and status codes and state encoding.
// No dependencies.
`timescale 1ns / 1ps

package tlptm_pkg;

    localparam int IDX_W         = 10;
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int OFS_W         = 12;
    localparam int FRAME_W       = 20;
    localparam int VA_DIR_LSB    = 22;
    localparam int VA_TBL_LSB    = 12;
    localparam logic [FRAME_W-1:0] POOL_BASE_RESET = 20'd1024;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXHAUSTED   = 2'd1,
        ST_NOT_PRESENT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DIR,
        S_CLEAR,
        S_TBL,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] vaddr;
        logic [31:0] paddr;
        logic [11:0] page_flags;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] translated_addr;
        logic        table_allocated;
    } t_out;

endpackage

/* rtl/core/tlptm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module tlptm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/two_level_page_table_manager_core.sv */
// Top level of the two-level page table manager core.
// Depends on tlptm_pkg and tlptm_ram.
`timescale 1ns / 1ps

// Each input beat carries a map, unmap, translate or no-op for a 32-bit virtual
// address; each one yields exactly one result beat. Both channels use valid and
// ready. The directory lives in a 1024-entry RAM and all second-level tables
// share a second RAM of POOL_TABLES * 1024 PTEs, both with a registered read.
// A map or unmap of a present slot does a directory read, then the PTE write
// together with the result. A translate adds a PTE read. A map that allocates a
// table sweeps the new table, one PTE per cycle. The input is taken only while
// no item is in progress. A finished result sits in an output register, so the
// next item is accepted while it waits; if the receiver still stalls when the
// following result is ready, that result is parked and the block waits.
// After reset the block clears the directory and does not accept items in that
// time; configuration writes are taken at any time.
// Tables are never returned to the pool, so pool use is a simple count.
module two_level_page_table_manager_core #(
    parameter int POOL_TABLES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  tlptm_pkg::t_in                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output tlptm_pkg::t_out                 o_out_data,
    input  logic                            i_cfg_we,
    input  logic [tlptm_pkg::FRAME_W-1:0]   i_cfg_wdata
);

    localparam int TW        = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
    localparam int CW        = $clog2(POOL_TABLES + 1);
    localparam int DIR_W     = TW + 1;
    localparam int TBL_DEPTH = POOL_TABLES * tlptm_pkg::TABLE_ENTRIES;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int IW        = tlptm_pkg::IDX_W;

    tlptm_pkg::t_state r_state, n_state;
    tlptm_pkg::t_in    r_item, n_item;
    tlptm_pkg::t_out   r_out, n_out;
    tlptm_pkg::t_out   r_hold, n_hold;
    logic              r_out_valid, n_out_valid;
    logic [IW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_pool_count, n_pool_count;
    logic [TW-1:0]     r_tbl, n_tbl;
    logic [tlptm_pkg::FRAME_W-1:0] r_pool_base_page;

    logic              w_dir_we;
    logic [IW-1:0]     w_dir_waddr;
    logic [DIR_W-1:0]  w_dir_wdata;
    logic [DIR_W-1:0]  w_dir_rdata;
    logic              w_tbl_we;
    logic [TW-1:0]     w_tbl_wsel;
    logic [IW-1:0]     w_tbl_widx;
    logic [31:0]       w_tbl_wdata;
    logic [31:0]       w_tbl_rdata;
    logic [TW+IW-1:0]  w_tbl_wfull;
    logic [TW+IW-1:0]  w_tbl_rfull;
    logic [TBL_AW-1:0] w_tbl_waddr;
    logic [TBL_AW-1:0] w_tbl_raddr;

    logic              w_done;
    tlptm_pkg::t_out   w_res;
    logic              w_out_free;
    logic              w_present;
    logic [TW-1:0]     w_rd_tbl;
    logic [IW-1:0]     w_ti;
    logic [31:0]       w_pte;

    assign w_present  = w_dir_rdata[TW];
    assign w_rd_tbl   = w_dir_rdata[TW-1:0];
    assign w_ti       = r_item.vaddr[tlptm_pkg::VA_TBL_LSB +: IW];
    assign w_pte      = {r_item.paddr[31:tlptm_pkg::OFS_W], r_item.page_flags};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_tbl_wfull = {w_tbl_wsel, w_tbl_widx};
    assign w_tbl_rfull = {w_rd_tbl, w_ti};
    assign w_tbl_waddr = w_tbl_wfull[TBL_AW-1:0];
    assign w_tbl_raddr = w_tbl_rfull[TBL_AW-1:0];

    tlptm_ram #(
        .WIDTH(DIR_W),
        .DEPTH(tlptm_pkg::DIR_ENTRIES)
    ) u_dir_ram (
        .i_clk  (i_clk),
        .i_we   (w_dir_we),
        .i_waddr(w_dir_waddr),
        .i_wdata(w_dir_wdata),
        .i_raddr(i_in_data.vaddr[tlptm_pkg::VA_DIR_LSB +: IW]),
        .o_rdata(w_dir_rdata)
    );

    tlptm_ram #(
        .WIDTH(32),
        .DEPTH(TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk  (i_clk),
        .i_we   (w_tbl_we),
        .i_waddr(w_tbl_waddr),
        .i_wdata(w_tbl_wdata),
        .i_raddr(w_tbl_raddr),
        .o_rdata(w_tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= tlptm_pkg::S_INIT;
            r_out_valid      <= 1'b0;
            r_cnt            <= '0;
            r_pool_count     <= '0;
            r_pool_base_page <= tlptm_pkg::POOL_BASE_RESET;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
            r_pool_count <= n_pool_count;
            if (i_cfg_we) begin
                r_pool_base_page <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        r_hold <= n_hold;
        r_tbl  <= n_tbl;
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_out        = r_out;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_cnt        = r_cnt;
        n_pool_count = r_pool_count;
        n_tbl        = r_tbl;
        o_in_ready   = 1'b0;
        w_dir_we     = 1'b0;
        w_dir_waddr  = r_item.vaddr[tlptm_pkg::VA_DIR_LSB +: IW];
        w_dir_wdata  = '0;
        w_tbl_we     = 1'b0;
        w_tbl_wsel   = w_rd_tbl;
        w_tbl_widx   = w_ti;
        w_tbl_wdata  = '0;
        w_done       = 1'b0;
        w_res        = '0;

        case (r_state)
            tlptm_pkg::S_INIT: begin
                w_dir_we    = 1'b1;
                w_dir_waddr = r_cnt;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == IW'(tlptm_pkg::DIR_ENTRIES - 1)) begin
                    n_state = tlptm_pkg::S_IDLE;
                end
            end
            tlptm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = tlptm_pkg::S_DIR;
                end
            end
            tlptm_pkg::S_DIR: begin
                case (r_item.op)
                    tlptm_pkg::OP_MAP: begin
                        if (w_present) begin
                            w_tbl_we    = 1'b1;
                            w_tbl_wdata = w_pte;
                            w_done      = 1'b1;
                        end else if (r_pool_count == CW'(POOL_TABLES)) begin
                            w_res.status = tlptm_pkg::ST_EXHAUSTED;
                            w_done       = 1'b1;
                        end else begin
                            w_dir_we     = 1'b1;
                            w_dir_wdata  = {1'b1, r_pool_count[TW-1:0]};
                            n_tbl        = r_pool_count[TW-1:0];
                            n_pool_count = r_pool_count + 1'b1;
                            n_cnt        = '0;
                            n_state      = tlptm_pkg::S_CLEAR;
                        end
                    end
                    tlptm_pkg::OP_UNMAP: begin
                        w_tbl_we = w_present;
                        w_done   = 1'b1;
                    end
                    tlptm_pkg::OP_XLATE: begin
                        if (w_present) begin
                            n_state = tlptm_pkg::S_TBL;
                        end else begin
                            w_res.status = tlptm_pkg::ST_NOT_PRESENT;
                            w_done       = 1'b1;
                        end
                    end
                    default: begin
                        w_done = 1'b1;
                    end
                endcase
            end
            tlptm_pkg::S_CLEAR: begin
                w_tbl_we    = 1'b1;
                w_tbl_wsel  = r_tbl;
                w_tbl_widx  = r_cnt;
                w_tbl_wdata = (r_cnt == w_ti) ? w_pte : 32'd0;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == IW'(tlptm_pkg::TABLE_ENTRIES - 1)) begin
                    w_res.table_allocated = 1'b1;
                    w_done                = 1'b1;
                end
            end
            tlptm_pkg::S_TBL: begin
                if (w_tbl_rdata[0]) begin
                    w_res.translated_addr = {w_tbl_rdata[31:tlptm_pkg::OFS_W],
                                             r_item.vaddr[tlptm_pkg::OFS_W-1:0]};
                end else begin
                    w_res.status = tlptm_pkg::ST_NOT_PRESENT;
                end
                w_done = 1'b1;
            end
            tlptm_pkg::S_HOLD: begin
                if (w_out_free) begin
                    n_out       = r_hold;
                    n_out_valid = 1'b1;
                    n_state     = tlptm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlptm_pkg::S_IDLE;
            end
        endcase

        if (w_done) begin
            if (w_out_free) begin
                n_out       = w_res;
                n_out_valid = 1'b1;
                n_state     = tlptm_pkg::S_IDLE;
            end else begin
                n_hold  = w_res;
                n_state = tlptm_pkg::S_HOLD;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_count <= CW'(POOL_TABLES))
        else $error("pool count exceeds the number of tables");

    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_allocated) |->
        (o_out_data.status == tlptm_pkg::ST_OK))
        else $error("table allocated with a failing status");

    a_pool_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_pool_count != $past(r_pool_count))) |->
        ($past(r_state) == tlptm_pkg::S_DIR
         && r_pool_count == $past(r_pool_count) + 1'b1))
        else $error("pool count moved outside a directory lookup");

    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlptm_pkg::S_HOLD) |-> r_out_valid)
        else $error("result parked while the output register is empty");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cfg_we) |=> (r_pool_base_page == $past(i_cfg_wdata)))
        else $error("pool base register missed a write");
`endif

endmodule

/* tb/tlptm_walk_checker.sv */
// Checker for the two-level page table manager core: watches both channels and the
// configuration port, predicts every result beat and compares it with the block.
// Depends on tlptm_pkg.
`timescale 1ns / 1ps

module tlptm_walk_checker #(
    parameter int POOL_TABLES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  tlptm_pkg::t_in                i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  tlptm_pkg::t_out               i_out_data,
    input  logic                          i_cfg_we,
    input  logic [tlptm_pkg::FRAME_W-1:0] i_cfg_wdata,
    output int                            o_pending,
    output int                            o_errors
);
    import tlptm_pkg::*;

    logic                dir_valid [DIR_ENTRIES];
    int                  dir_table [DIR_ENTRIES];
    logic [31:0]         pte_mem [POOL_TABLES*TABLE_ENTRIES];
    int                  tables_taken;
    logic [FRAME_W-1:0]  pool_base;
    t_out                expected_results [$];

    initial begin
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            dir_valid[i] = 1'b0;
            dir_table[i] = 0;
        end
        for (int i = 0; i < POOL_TABLES*TABLE_ENTRIES; i++) begin
            pte_mem[i] = '0;
        end
        tables_taken = 0;
        pool_base    = POOL_BASE_RESET;
        o_pending    = 0;
        o_errors     = 0;
    end

    function automatic t_out predict_walk(input t_in item);
        t_out r;
        int   di;
        int   ti;
        int   slot;
        r = '0;
        r.status = ST_OK;
        di = item.vaddr[VA_DIR_LSB +: IDX_W];
        ti = item.vaddr[VA_TBL_LSB +: IDX_W];
        case (item.op)
            OP_MAP: begin
                if (!dir_valid[di]) begin
                    if (tables_taken < POOL_TABLES) begin
                        for (int k = 0; k < TABLE_ENTRIES; k++) begin
                            pte_mem[tables_taken*TABLE_ENTRIES + k] = '0;
                        end
                        dir_valid[di] = 1'b1;
                        dir_table[di] = tables_taken;
                        tables_taken++;
                        r.table_allocated = 1'b1;
                    end else begin
                        r.status = ST_EXHAUSTED;
                    end
                end
                if (r.status == ST_OK) begin
                    slot = dir_table[di]*TABLE_ENTRIES + ti;
                    pte_mem[slot] = {item.paddr[31:OFS_W], item.page_flags};
                end
            end
            OP_UNMAP: begin
                if (dir_valid[di]) begin
                    pte_mem[dir_table[di]*TABLE_ENTRIES + ti] = '0;
                end
            end
            OP_XLATE: begin
                r.status = ST_NOT_PRESENT;
                if (dir_valid[di]) begin
                    slot = dir_table[di]*TABLE_ENTRIES + ti;
                    if (pte_mem[slot][0]) begin
                        r.status = ST_OK;
                        r.translated_addr = {pte_mem[slot][31:OFS_W],
                                             item.vaddr[OFS_W-1:0]};
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_out want, input t_out got);
        o_errors++;
        if (o_errors <= 10) begin
            $display({"%0t mismatch (%s): expected status=%0d addr=%h alloc=%0b,",
                      " got status=%0d addr=%h alloc=%0b"},
                     $realtime, what, want.status, want.translated_addr,
                     want.table_allocated, got.status, got.translated_addr,
                     got.table_allocated);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    want = '0;
                    note_mismatch("beat with nothing expected", want, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    o_pending--;
                    if (i_out_data.status !== want.status ||
                        i_out_data.translated_addr !== want.translated_addr ||
                        i_out_data.table_allocated !== want.table_allocated) begin
                        note_mismatch("field", want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_walk(i_in_data));
                o_pending++;
            end
            if (i_cfg_we) begin
                pool_base = i_cfg_wdata;
            end
        end
    end

endmodule

/* tb/tb.sv */
// Top of the testbench for the two-level page table manager core: clock, reset,
// directed and random beats with random idling, and the final verdict.
// Depends on tlptm_pkg, two_level_page_table_manager_core and tlptm_walk_checker.
`timescale 1ns / 1ps

module tb;
    import tlptm_pkg::*;

    localparam int POOL_TABLES    = 64;
    localparam int PHASE_ITEMS    = 450;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out_data;
    logic               i_cfg_we;
    logic [FRAME_W-1:0] i_cfg_wdata;
    int                 chk_pending;
    int                 chk_errors;
    int                 sent_count;
    int                 got_count;
    int                 idle_cycles;
    logic [19:0]        seen_pages [$];

    two_level_page_table_manager_core #(
        .POOL_TABLES(POOL_TABLES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    tlptm_walk_checker #(
        .POOL_TABLES(POOL_TABLES)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_pending  (chk_pending),
        .o_errors   (chk_errors)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap(input int n);
        if ((n / 150) % 4 == 3) begin
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic send(input t_in item);
        int gap;
        gap = pick_gap(sent_count);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = item;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic drive_op(input t_op op, input logic [31:0] va, input logic [31:0] pa,
                            input logic [11:0] flags);
        t_in item;
        item.op         = op;
        item.vaddr      = va;
        item.paddr      = pa;
        item.page_flags = flags;
        send(item);
    endtask

    task automatic write_cfg(input logic [FRAME_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_in random_item();
        t_in         item;
        int          sel;
        logic [19:0] page;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            item.op = OP_MAP;
        end else if (sel < 60) begin
            item.op = OP_UNMAP;
        end else if (sel < 95) begin
            item.op = OP_XLATE;
        end else begin
            item.op = OP_NOP;
        end
        item.paddr      = $urandom;
        item.page_flags = 12'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            item.page_flags[0] = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (seen_pages.size() > 0 && sel < 85) begin
            page = seen_pages[$urandom_range(0, seen_pages.size() - 1)];
            if (sel >= 70) begin
                page[9:0] = 10'($urandom);
            end
        end else begin
            page = 20'($urandom);
        end
        item.vaddr        = $urandom;
        item.vaddr[31:12] = page;
        if (item.op == OP_MAP) begin
            if (seen_pages.size() < 64) begin
                seen_pages.push_back(page);
            end else begin
                seen_pages[$urandom_range(0, 63)] = page;
            end
        end
        return item;
    endfunction

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin : receiver
        int gap;
        i_out_ready = 1'b0;
        got_count   = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (got_count == 200 || got_count == 1000) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = pick_gap(got_count);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
            got_count++;
        end
    end

    initial begin : stimulus
        logic [FRAME_W-1:0] phase_cfg [4];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        sent_count  = 0;
        idle_cycles = 0;
        phase_cfg[0] = 20'hFFFFF;
        phase_cfg[1] = 20'($urandom_range(0, 20'hFFFFF));
        phase_cfg[2] = 20'h00001;
        phase_cfg[3] = POOL_BASE_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_cfg(20'h00000);

        drive_op(OP_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);
        drive_op(OP_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        drive_op(OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        drive_op(OP_XLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000);
        drive_op(OP_MAP,   32'h0000_1000, 32'h1234_5678, 12'hFFE);
        drive_op(OP_XLATE, 32'h0000_1ABC, 32'h0000_0000, 12'h000);
        drive_op(OP_MAP,   32'hFFFF_FFFF, 32'h0000_0000, 12'h001);
        drive_op(OP_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        drive_op(OP_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 12'h000);
        drive_op(OP_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000);
        drive_op(OP_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        drive_op(OP_NOP,   32'h0000_0000, 32'h0000_0000, 12'h000);
        drive_op(OP_MAP,   32'hFFC0_0000, 32'hA5A5_A000, 12'h003);
        drive_op(OP_XLATE, 32'hFFC0_0123, 32'h0000_0000, 12'h000);
        drive_op(OP_UNMAP, 32'h0040_0000, 32'h0000_0000, 12'h000);
        drive_op(OP_XLATE, 32'h003F_F000, 32'h0000_0000, 12'h000);
        drive_op(OP_MAP,   32'h0000_0000, 32'h5555_5000, 12'hAAB);
        drive_op(OP_XLATE, 32'h0000_0AAA, 32'h0000_0000, 12'h000);
        drive_op(OP_UNMAP, 32'h0000_0000, 32'h0000_0000, 12'h000);
        drive_op(OP_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000);

        for (int p = 0; p < 4; p++) begin
            drain();
            write_cfg(phase_cfg[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send(random_item());
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
